@@ rtl/core/pth_pkg.sv @@
package pth_pkg;

	localparam int COORD_W = 12;
	localparam int TOL_W   = 8;

	localparam logic [TOL_W-1:0] TOL_RESET = 8'd12;

	// request kinds
	localparam logic [1:0] REQ_ADD    = 2'd0;
	localparam logic [1:0] REQ_REMOVE = 2'd1;
	localparam logic [1:0] REQ_SELECT = 2'd2;

	// result status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_FULL     = 3'd1;
	localparam logic [2:0] ST_EMPTY    = 3'd2;
	localparam logic [2:0] ST_NOTFOUND = 3'd3;
	localparam logic [2:0] ST_BADINDEX = 3'd4;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [COORD_W-1:0] coord_x;
		logic [COORD_W-1:0] coord_y;
		logic [5:0]         point_index;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [5:0] hit_index;
		logic [6:0] point_count;
	} rsp_t;

endpackage

@@ rtl/core/point_table_with_hit_test.sv @@
// add and rejected requests: S_IDLE to S_DONE, then into the result register once it is free
// select: entries read in index order, one entry read per cycle, stopping at the first hit
// remove: entries after the hole move down one place, one entry moved per cycle
// throughput: one request at a time, the next is taken once the result is registered
// reset: count and pending result cleared, tolerance back to 12, table contents undefined
module point_table_with_hit_test #(
	parameter int MAX_POINTS = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	// configuration port
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [1:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready,
	// request channel
	input  logic          req_valid,
	output logic          req_stall,
	input  pth_pkg::req_t req,
	// result channel
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output pth_pkg::rsp_t rsp
);
	import pth_pkg::*;

	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1; // table address
	localparam int CW = $clog2(MAX_POINTS + 1);                      // count, holds MAX_POINTS
	localparam int IW = (CW > 6) ? CW : 6;                           // index compare width
	localparam int DW = 2 * COORD_W;                                 // packed x,y entry
	localparam int EW = COORD_W + 2;                                 // hit compare width

	// register map: hit tolerance at byte address 0
	localparam logic [1:0] ADDR_HIT_TOL = 2'd0;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEL,
		S_REM,
		S_DONE
	} state_t;

	state_t             state_q;
	logic [CW-1:0]      cnt_q;      // points held
	logic [CW-1:0]      ptr_q;      // walk read pointer
	logic [TOL_W-1:0]   tol_q;
	logic [COORD_W-1:0] cx_q;
	logic [COORD_W-1:0] cy_q;
	logic [2:0]         res_status_q;
	logic [AW-1:0]      res_hit_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	// table memory, x in the upper half, y in the lower half
	logic [DW-1:0]      mem_q [MAX_POINTS];
	logic [DW-1:0]      rd_data_s1;
	logic [AW-1:0]      rd_idx_s1;
	logic               rd_valid_s1;

	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [DW-1:0]      mem_wdata;
	logic               mem_re;
	logic [AW-1:0]      mem_raddr;

	logic               cfg_wr;
	logic               not_full;
	logic               rsp_load;
	logic [COORD_W-1:0] px;
	logic [COORD_W-1:0] py;
	logic               hit;

	assign pready    = 1'b1;
	assign prdata    = {{(32-TOL_W){1'b0}}, tol_q};
	assign cfg_wr    = psel && penable && pwrite && (paddr == ADDR_HIT_TOL);
	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign not_full  = (cnt_q < CW'(MAX_POINTS));
	// result register takes the finished request once it is empty or being drained
	assign rsp_load  = (state_q == S_DONE) && (!rsp_valid_q || !rsp_stall);

	// shared square test on the entry just read: edges count as inside,
	// widened so that neither side of the square wraps
	assign px  = rd_data_s1[DW-1:COORD_W];
	assign py  = rd_data_s1[COORD_W-1:0];
	assign hit = (EW'(cx_q) <= EW'(px) + EW'(tol_q)) &&
	             (EW'(cx_q) + EW'(tol_q) >= EW'(px)) &&
	             (EW'(cy_q) <= EW'(py) + EW'(tol_q)) &&
	             (EW'(cy_q) + EW'(tol_q) >= EW'(py));

	// memory port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cnt_q[AW-1:0];
		mem_wdata = {req.coord_x, req.coord_y};
		mem_re    = 1'b0;
		mem_raddr = ptr_q[AW-1:0];
		case (state_q)
			S_IDLE: begin
				// append goes straight into the free slot at the end
				mem_we = req_valid && (req.req_type == REQ_ADD) && not_full;
			end
			S_SEL: begin
				// stop issuing reads once a hit shows up
				mem_re = (ptr_q < cnt_q) && !(rd_valid_s1 && hit);
			end
			S_REM: begin
				// read the entry at the pointer while writing the previously read entry to its index minus one
				mem_re = (ptr_q < cnt_q);
				if (rd_valid_s1) begin
					mem_we    = 1'b1;
					mem_waddr = rd_idx_s1 - AW'(1);
					mem_wdata = rd_data_s1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_s1 <= mem_q[mem_raddr];
			rd_idx_s1  <= mem_raddr;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			ptr_q        <= '0;
			tol_q        <= TOL_RESET;
			rd_valid_s1  <= 1'b0;
			rsp_valid_q  <= 1'b0;
			rsp_q        <= '0;
			cx_q         <= '0;
			cy_q         <= '0;
			res_status_q <= ST_OK;
			res_hit_q    <= '0;
		end else begin
			if (cfg_wr) begin
				tol_q <= pwdata[TOL_W-1:0];
			end
			rd_valid_s1 <= mem_re;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						cx_q      <= req.coord_x;
						cy_q      <= req.coord_y;
						res_hit_q <= '0;
						case (req.req_type)
							REQ_ADD: begin
								if (not_full) begin
									cnt_q        <= cnt_q + CW'(1);
									res_status_q <= ST_OK;
								end else begin
									res_status_q <= ST_FULL;
								end
								state_q <= S_DONE;
							end
							REQ_REMOVE: begin
								if (cnt_q == '0) begin
									res_status_q <= ST_EMPTY;
									state_q      <= S_DONE;
								end else if (IW'(req.point_index) >= IW'(cnt_q)) begin
									res_status_q <= ST_BADINDEX;
									state_q      <= S_DONE;
								end else begin
									// first entry to move down is the one after the hole
									ptr_q   <= CW'(req.point_index) + CW'(1);
									state_q <= S_REM;
								end
							end
							REQ_SELECT: begin
								if (cnt_q == '0) begin
									res_status_q <= ST_EMPTY;
									state_q      <= S_DONE;
								end else begin
									ptr_q        <= '0;
									res_status_q <= ST_NOTFOUND;
									state_q      <= S_SEL;
								end
							end
							default: begin
								// unused kind leaves the table alone
								res_status_q <= ST_BADINDEX;
								state_q      <= S_DONE;
							end
						endcase
					end
				end
				S_SEL: begin
					if (mem_re) begin
						ptr_q <= ptr_q + CW'(1);
					end
					if (rd_valid_s1 && hit) begin
						// reads go in index order, so the first hit is the lowest
						res_status_q <= ST_OK;
						res_hit_q    <= rd_idx_s1;
						state_q      <= S_DONE;
					end else if (!mem_re && !rd_valid_s1) begin
						state_q <= S_DONE;
					end
				end
				S_REM: begin
					if (mem_re) begin
						ptr_q <= ptr_q + CW'(1);
					end
					if (!mem_re && !rd_valid_s1) begin
						// last move written, drop the tail entry
						cnt_q        <= cnt_q - CW'(1);
						res_status_q <= ST_OK;
						state_q      <= S_DONE;
					end
				end
				S_DONE: begin
					// wait for the result register to be free
					if (rsp_load) begin
						rsp_q.status      <= res_status_q;
						rsp_q.hit_index   <= 6'(res_hit_q);
						rsp_q.point_count <= 7'(cnt_q);
						state_q           <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
